[hdl/wssp_pkg.sv]
`timescale 1ns / 1ps

package wssp_pkg;

	// Request operation codes
	localparam logic OP_SHARE = 1'b0;
	localparam logic OP_GET   = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DELIVERED = 2'd0;
	localparam logic [1:0] ST_NO_WORK   = 2'd1;
	localparam logic [1:0] ST_DROPPED   = 2'd2;
	localparam logic [1:0] ST_ACCEPTED  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_ACTIVE_WORKERS = 1'b0;
	localparam logic CFG_BATCH_LIMIT    = 1'b1;

	// Register reset values and batch ceiling
	localparam logic [3:0] ACTIVE_RESET = 4'd8;
	localparam logic [6:0] BATCH_RESET  = 7'd64;
	localparam logic [6:0] MAX_BATCH    = 7'd64;

	// Source of a result loaded into the output register
	typedef enum logic [1:0] {
		EMIT_SHARE,
		EMIT_NO_WORK,
		EMIT_MORE,
		EMIT_LAST
	} wssp_emit_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load_req;
		logic       get_init;
		logic       share_wr;
		logic       pop;
		logic       go_n1;
		logic       go_n2;
		logic       take_item;
		logic       emit;
		wssp_emit_t emit_kind;
	} wssp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic op_get;
		logic id_ok;
		logic fill_zero;
		logic cnt_zero;
		logic cnt_at_lim;
		logic more_dist;
		logic n2_ok;
		logic pend_v;
		logic out_free;
	} wssp_sts_t;

endpackage

[hdl/wssp_ram.sv]
`timescale 1ns / 1ps

module wssp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/wssp_dp.sv]
`timescale 1ns / 1ps

module wssp_dp #(
	parameter int MAX_WORKERS = 8,
	parameter int STACK_DEPTH = 256,
	parameter int ITEM_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_index,
	input  logic [6:0]         cfg_data,
	input  logic               operation,
	input  logic [2:0]         worker_id,
	input  logic [31:0]        item_value,
	input  wssp_pkg::wssp_cmd_t cmd,
	output wssp_pkg::wssp_sts_t sts,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         status,
	output logic [31:0]        out_item,
	output logic [2:0]         source_worker,
	output logic               last_result
);

	localparam int WI        = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW        = $clog2(MAX_WORKERS + 1);
	localparam int RW        = (NW + 1 > 4) ? NW + 1 : 4;
	localparam int FW        = $clog2(STACK_DEPTH + 1);
	localparam int MEM_DEPTH = MAX_WORKERS * STACK_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);

	// Configuration
	logic [3:0] active_q;
	logic [6:0] batch_q;

	// Request and search state
	logic                  op_q;
	logic [2:0]            req_id_q;
	logic [ITEM_WIDTH-1:0] req_item_q;
	logic [WI-1:0]         w_q;
	logic [RW-1:0]         d_q;
	logic [6:0]            cnt_q;
	logic [FW-1:0]         fill_q [MAX_WORKERS];

	// Held-back item, so the final one can carry the last flag
	logic                  pend_v_q;
	logic [ITEM_WIDTH-1:0] pend_q;
	logic [WI-1:0]         pend_src_q;

	// Output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [31:0] out_item_q;
	logic [2:0]  source_q;
	logic        last_q;

	logic [RW-1:0] act_r, maxw_r, n_r, id_r, w_r, d_nx, dmax_r, s1, s2, n1_r, n2_r;
	logic [6:0]    lim;
	logic [FW-1:0] fill_w, fill_dec;
	logic          id_ok, full, share_ok, out_free;
	logic [AW-1:0] base_addr, wr_addr, rd_addr;
	logic [ITEM_WIDTH-1:0] rd_data;

	// Clamp registers to their working ranges
	always_comb begin
		act_r  = RW'(active_q);
		maxw_r = RW'(MAX_WORKERS);
		if (act_r == '0) begin
			n_r = RW'(1);
		end else if (act_r > maxw_r) begin
			n_r = maxw_r;
		end else begin
			n_r = act_r;
		end
		if (batch_q == '0) begin
			lim = 7'd1;
		end else if (batch_q > wssp_pkg::MAX_BATCH) begin
			lim = wssp_pkg::MAX_BATCH;
		end else begin
			lim = batch_q;
		end
	end

	// Ring neighbors: both sums stay below 2n, so one subtract wraps them
	always_comb begin
		id_r   = RW'(req_id_q);
		w_r    = RW'(w_q);
		d_nx   = d_q + RW'(1);
		dmax_r = n_r >> 1;
		s1     = id_r + d_nx;
		s2     = id_r + n_r - d_q;
		n1_r   = (s1 >= n_r) ? s1 - n_r : s1;
		n2_r   = (s2 >= n_r) ? s2 - n_r : s2;
	end

	// Stack of the current worker
	assign fill_w    = fill_q[w_q];
	assign fill_dec  = fill_w - FW'(1);
	assign id_ok     = id_r < n_r;
	assign full      = fill_w == FW'(STACK_DEPTH);
	assign share_ok  = id_ok && !full;
	assign base_addr = AW'(AW'(w_q) * AW'(STACK_DEPTH));
	assign wr_addr   = base_addr + AW'(fill_w);
	assign rd_addr   = base_addr + AW'(fill_dec);
	assign out_free  = !out_valid_q || out_ready;

	// Status toward the controller
	always_comb begin
		sts.op_get     = op_q == wssp_pkg::OP_GET;
		sts.id_ok      = id_ok;
		sts.fill_zero  = fill_w == '0;
		sts.cnt_zero   = cnt_q == '0;
		sts.cnt_at_lim = cnt_q >= lim;
		sts.more_dist  = d_nx <= dmax_r;
		sts.n2_ok      = (w_r != id_r) && (n2_r != id_r) && (n2_r != w_r);
		sts.pend_v     = pend_v_q;
		sts.out_free   = out_free;
	end

	wssp_ram #(
		.WIDTH(ITEM_WIDTH),
		.DEPTH(MEM_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.share_wr && share_ok),
		.waddr(wr_addr),
		.wdata(req_item_q),
		.re   (cmd.pop),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= wssp_pkg::ACTIVE_RESET;
			batch_q     <= wssp_pkg::BATCH_RESET;
			cnt_q       <= '0;
			d_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			// Take configuration writes
			if (cfg_valid) begin
				if (cfg_index == wssp_pkg::CFG_ACTIVE_WORKERS) begin
					active_q <= cfg_data[3:0];
				end else begin
					batch_q <= cfg_data;
				end
			end
			if (cmd.get_init) begin
				cnt_q <= '0;
				d_q   <= '0;
			end
			// Pop one entry and count it
			if (cmd.pop) begin
				cnt_q     <= cnt_q + 7'd1;
				fill_q[w_q] <= fill_dec;
			end
			// Push on an accepted share
			if (cmd.share_wr && share_ok) begin
				fill_q[w_q] <= fill_w + FW'(1);
			end
			if (cmd.go_n1) begin
				d_q <= d_nx;
			end
			if (cmd.take_item) begin
				pend_v_q <= 1'b1;
			end else if (cmd.emit && cmd.emit_kind == wssp_pkg::EMIT_LAST) begin
				pend_v_q <= 1'b0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q       <= operation;
			req_id_q   <= worker_id;
			req_item_q <= ITEM_WIDTH'(item_value);
			w_q        <= WI'(worker_id);
		end
		if (cmd.go_n1) begin
			w_q <= WI'(n1_r);
		end
		if (cmd.go_n2) begin
			w_q <= WI'(n2_r);
		end
		if (cmd.take_item) begin
			pend_q     <= rd_data;
			pend_src_q <= w_q;
		end
		// Load the output register
		if (cmd.emit) begin
			case (cmd.emit_kind)
				wssp_pkg::EMIT_SHARE: begin
					status_q   <= share_ok ? wssp_pkg::ST_ACCEPTED : wssp_pkg::ST_DROPPED;
					out_item_q <= '0;
					source_q   <= req_id_q;
					last_q     <= 1'b1;
				end
				wssp_pkg::EMIT_NO_WORK: begin
					status_q   <= wssp_pkg::ST_NO_WORK;
					out_item_q <= '0;
					source_q   <= req_id_q;
					last_q     <= 1'b1;
				end
				wssp_pkg::EMIT_MORE: begin
					status_q   <= wssp_pkg::ST_DELIVERED;
					out_item_q <= 32'(pend_q);
					source_q   <= 3'(pend_src_q);
					last_q     <= 1'b0;
				end
				default: begin
					status_q   <= wssp_pkg::ST_DELIVERED;
					out_item_q <= 32'(pend_q);
					source_q   <= 3'(pend_src_q);
					last_q     <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_item      = out_item_q;
	assign source_worker = source_q;
	assign last_result   = last_q;

endmodule

[hdl/wssp_ctrl.sv]
`timescale 1ns / 1ps

module wssp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wssp_pkg::wssp_sts_t sts,
	output wssp_pkg::wssp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SHARE,
		S_CHECK,
		S_FETCH,
		S_NO_WORK,
		S_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		PH_OWN,
		PH_N1,
		PH_N2
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   in_ready_q;

	// Next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (!sts.op_get) begin
					state_d = S_SHARE;
				end else if (!sts.id_ok) begin
					state_d = S_NO_WORK;
				end else begin
					cmd.get_init = 1'b1;
					phase_d      = PH_OWN;
					state_d      = S_CHECK;
				end
			end
			S_SHARE: begin
				if (sts.out_free) begin
					cmd.share_wr  = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = wssp_pkg::EMIT_SHARE;
					state_d       = S_IDLE;
				end
			end
			S_CHECK: begin
				// Pop the current stack, else move on through the search
				if (!sts.fill_zero && !sts.cnt_at_lim) begin
					cmd.pop = 1'b1;
					state_d = S_FETCH;
				end else if (phase_q == PH_N1 && !sts.cnt_at_lim && sts.n2_ok) begin
					cmd.go_n2 = 1'b1;
					phase_d   = PH_N2;
				end else if (!sts.cnt_zero) begin
					state_d = S_FLUSH;
				end else if (sts.more_dist) begin
					cmd.go_n1 = 1'b1;
					phase_d   = PH_N1;
				end else begin
					state_d = S_NO_WORK;
				end
			end
			S_FETCH: begin
				// Hold the new item back; release the previous one
				if (!sts.pend_v || sts.out_free) begin
					cmd.take_item = 1'b1;
					cmd.emit      = sts.pend_v;
					cmd.emit_kind = wssp_pkg::EMIT_MORE;
					state_d       = S_CHECK;
				end
			end
			S_NO_WORK: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = wssp_pkg::EMIT_NO_WORK;
					state_d       = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = wssp_pkg::EMIT_LAST;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, phase and registered ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_OWN;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			in_ready_q <= state_d == S_IDLE;
		end
	end

	assign in_ready = in_ready_q;

endmodule

[hdl/work_stealing_stack_pool.sv]
// Share request: registered in IDLE, decoded in DISPATCH, then written and answered in SHARE
//   once the output register is free. Get request: each delivered item passes the stack memory
//   read, then the hold-back register; each stack probed is a CHECK step; dispatch and flush frame it.
// One request is in work at a time; a finished result may wait in the output register.
// Reset (arst_n low, asynchronous): all stacks empty, active_workers 8, batch_limit 64.
// Stack memory is not cleared; only entries below a stack's fill count are read.
`timescale 1ns / 1ps

module work_stealing_stack_pool #(
	parameter int MAX_WORKERS = 8,
	parameter int STACK_DEPTH = 256,
	parameter int ITEM_WIDTH  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [2:0]  worker_id,
	input  logic [31:0] item_value,
	input  logic        batch_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_item,
	output logic [2:0]  source_worker,
	output logic        last_result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);

	wssp_pkg::wssp_cmd_t cmd;
	wssp_pkg::wssp_sts_t sts;

	// Registers take a write in any cycle
	assign cfg_ready = 1'b1;

	wssp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	wssp_dp #(
		.MAX_WORKERS(MAX_WORKERS),
		.STACK_DEPTH(STACK_DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (operation),
		.worker_id    (worker_id),
		.item_value   (item_value),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.status       (status),
		.out_item     (out_item),
		.source_worker(source_worker),
		.last_result  (last_result)
	);

	// A request in work blocks the next one
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in work");

	// A result is only loaded when the output register can take it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("result overwritten in output register");

	// Pops never exceed the batch limit
	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !sts.cnt_at_lim)
		else $error("pop beyond batch limit");

	// Non-delivery results carry no item and end the request
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != wssp_pkg::ST_DELIVERED |-> out_item == '0 && last_result)
		else $error("malformed status result");

endmodule

[sim/wssp_checker.sv]
`timescale 1ns / 1ps

module wssp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [2:0]  worker_id,
	input  logic [31:0] item_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] out_item,
	input  logic [2:0]  source_worker,
	input  logic        last_result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          replies_owed,
	output int          mismatches
);

	localparam int WORKERS = 8;
	localparam int DEPTH   = 256;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] item;
		logic [2:0]  source;
		logic        last;
	} reply_t;

	// Shadow of the pool: per-worker stacks, fill counts and registers
	reply_t      owed_replies[$];
	logic [31:0] stack_mem [0:WORKERS-1][0:DEPTH-1];
	int          fill_cnt [0:WORKERS-1];
	logic [3:0]  workers_reg;
	logic [6:0]  batch_reg;
	reply_t      want;

	function automatic reply_t make_reply(input logic [1:0] st, input logic [31:0] item,
			input logic [2:0] src, input logic last);
		reply_t r;
		r.status = st;
		r.item   = item;
		r.source = src;
		r.last   = last;
		return r;
	endfunction

	// Pop one stack until it runs dry or the batch is full
	task automatic pop_stack(input int w, input int lim, inout int taken);
		while (fill_cnt[w] > 0 && taken < lim) begin
			fill_cnt[w] = fill_cnt[w] - 1;
			owed_replies.push_back(make_reply(wssp_pkg::ST_DELIVERED,
				stack_mem[w][fill_cnt[w]], 3'(w), 1'b0));
			taken++;
		end
	endtask

	// Work out every reply that one accepted request causes
	task automatic serve_request(input logic op, input logic [2:0] id, input logic [31:0] value);
		int n;
		int lim;
		int taken;
		int n1;
		int n2;
		int d;
		reply_t r;
		n     = (workers_reg == 0) ? 1 : (workers_reg > WORKERS) ? WORKERS : int'(workers_reg);
		lim   = (batch_reg == 0) ? 1 :
			(batch_reg > wssp_pkg::MAX_BATCH) ? int'(wssp_pkg::MAX_BATCH) : int'(batch_reg);
		taken = 0;
		if (op == wssp_pkg::OP_SHARE) begin
			if (id >= n || fill_cnt[id] >= DEPTH) begin
				owed_replies.push_back(make_reply(wssp_pkg::ST_DROPPED, '0, id, 1'b1));
			end else begin
				stack_mem[id][fill_cnt[id]] = value;
				fill_cnt[id] = fill_cnt[id] + 1;
				owed_replies.push_back(make_reply(wssp_pkg::ST_ACCEPTED, '0, id, 1'b1));
			end
		end else if (id >= n) begin
			owed_replies.push_back(make_reply(wssp_pkg::ST_NO_WORK, '0, id, 1'b1));
		end else begin
			pop_stack(id, lim, taken);
			// Steal outward on the ring, right neighbor before left
			for (d = 1; taken == 0 && d <= n / 2; d++) begin
				n1 = (id + d) % n;
				n2 = (id + n - d) % n;
				pop_stack(n1, lim, taken);
				if (n1 != id && n2 != id && n2 != n1 && taken < lim)
					pop_stack(n2, lim, taken);
			end
			if (taken == 0) begin
				owed_replies.push_back(make_reply(wssp_pkg::ST_NO_WORK, '0, id, 1'b1));
			end else begin
				// Mark the final delivery of this request
				r = owed_replies.pop_back();
				r.last = 1'b1;
				owed_replies.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_replies.delete();
			for (int w = 0; w < WORKERS; w++)
				fill_cnt[w] = 0;
			workers_reg  = wssp_pkg::ACTIVE_RESET;
			batch_reg    = wssp_pkg::BATCH_RESET;
			mismatches   = 0;
			replies_owed <= 0;
		end else begin
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == wssp_pkg::CFG_ACTIVE_WORKERS)
					workers_reg = cfg_data[3:0];
				else
					batch_reg = cfg_data;
			end
			// Compare each reply against the oldest owed one
			if (out_valid && out_ready) begin
				if (owed_replies.size() == 0) begin
					$error("unexpected reply: status %0d item %h source %0d last %0d",
						status, out_item, source_worker, last_result);
					mismatches++;
				end else begin
					want = owed_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						mismatches++;
					end
					if (out_item !== want.item) begin
						$error("out_item: expected %h, actual %h", want.item, out_item);
						mismatches++;
					end
					if (source_worker !== want.source) begin
						$error("source_worker: expected %0d, actual %0d", want.source,
							source_worker);
						mismatches++;
					end
					if (last_result !== want.last) begin
						$error("last_result: expected %0d, actual %0d", want.last, last_result);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				serve_request(operation, worker_id, item_value);
			replies_owed <= owed_replies.size();
		end
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [2:0]  worker_id;
	logic [31:0] item_value;
	logic        batch_end;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] out_item;
	logic [2:0]  source_worker;
	logic        last_result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	int          replies_owed;
	int          mismatches;
	logic        calm = 1'b0;
	int          stall_left = 0;
	int          quiet_cycles = 0;

	work_stealing_stack_pool u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.worker_id    (worker_id),
		.item_value   (item_value),
		.batch_end    (batch_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_item     (out_item),
		.source_worker(source_worker),
		.last_result  (last_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	wssp_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.worker_id    (worker_id),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.out_item     (out_item),
		.source_worker(source_worker),
		.last_result  (last_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.replies_owed (replies_owed),
		.mismatches   (mismatches)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Stall the reply side in random bursts unless the phase is calm
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			out_ready  <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 4) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("** work_stealing_stack_pool: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request, with an optional idle burst ahead of it
	task automatic issue_request(input logic op, input logic [2:0] id, input logic [31:0] value,
			input logic last_of_batch);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		worker_id  <= id;
		item_value <= value;
		batch_end  <= last_of_batch;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Hold requests until every owed reply has drained, then let the block go idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write both registers back to back
	task automatic program_pool(input logic [6:0] workers, input logic [6:0] batch);
		cfg_valid <= 1'b1;
		cfg_index <= wssp_pkg::CFG_ACTIVE_WORKERS;
		cfg_data  <= workers;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= wssp_pkg::CFG_BATCH_LIMIT;
		cfg_data  <= batch;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_request(input int share_pct);
		logic        op;
		logic [31:0] value;
		op = ($urandom_range(0, 99) < share_pct) ? wssp_pkg::OP_SHARE : wssp_pkg::OP_GET;
		case ($urandom_range(0, 9))
			0: value = '0;
			1: value = '1;
			default: value = $urandom;
		endcase
		issue_request(op, 3'($urandom_range(0, 7)), value, 1'($urandom_range(0, 1)));
	endtask

	task automatic run_phase(input logic [6:0] workers, input logic [6:0] batch, input int count,
			input int share_pct, input logic quiet);
		settle();
		program_pool(workers, batch);
		calm <= quiet;
		repeat (count) random_request(share_pct);
	endtask

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		operation  <= wssp_pkg::OP_SHARE;
		worker_id  <= '0;
		item_value <= '0;
		batch_end  <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= wssp_pkg::CFG_ACTIVE_WORKERS;
		cfg_data   <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full ring: empty pool, own pops, far and near steals
		program_pool(7'd8, 7'd64);
		issue_request(wssp_pkg::OP_GET, 3'd0, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd7, 32'hFFFF_FFFF, 1'b1);
		issue_request(wssp_pkg::OP_SHARE, 3'd0, 32'h0000_0000, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd0, 32'hA5A5_5A5A, 1'b1);
		issue_request(wssp_pkg::OP_GET, 3'd0, 32'hFFFF_FFFF, 1'b1);
		issue_request(wssp_pkg::OP_GET, 3'd3, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd5, 32'h1234_5678, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd1, 32'h8765_4321, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd1, 32'hDEAD_BEEF, 1'b1);
		issue_request(wssp_pkg::OP_GET, 3'd3, 32'h5A5A_A5A5, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd6, 32'h0000_0001, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd6, 32'h8000_0000, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd6, 32'h7FFF_FFFE, 1'b1);
		issue_request(wssp_pkg::OP_GET, 3'd6, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_GET, 3'd7, 32'h0, 1'b0);

		// Three workers, one item per get: inactive ids and a split steal
		settle();
		program_pool(7'd3, 7'd1);
		issue_request(wssp_pkg::OP_SHARE, 3'd1, 32'hCAFE_0001, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd2, 32'hCAFE_0002, 1'b0);
		issue_request(wssp_pkg::OP_SHARE, 3'd2, 32'hCAFE_0003, 1'b1);
		issue_request(wssp_pkg::OP_SHARE, 3'd5, 32'hCAFE_0004, 1'b0);
		issue_request(wssp_pkg::OP_GET, 3'd6, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_GET, 3'd0, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_GET, 3'd0, 32'h0, 1'b0);
		issue_request(wssp_pkg::OP_GET, 3'd4, 32'h0, 1'b0);

		// Random phases across register settings, extremes included
		run_phase(7'd0, 7'd0, 20, 60, 1'b0);
		run_phase(7'd127, 7'd127, 20, 60, 1'b0);
		run_phase(7'd2, 7'd3, 20, 55, 1'b0);
		run_phase(7'd8, 7'd4, 20, 65, 1'($urandom_range(0, 1)));
		run_phase(7'd3, 7'd2, 20, 50, 1'b0);
		run_phase(7'd5, 7'd64, 20, 55, 1'b0);
		run_phase(7'd16, 7'd6, 20, 55, 1'b0);
		run_phase(7'd8, 7'd1, 20, 45, 1'($urandom_range(0, 1)));

		// Closing stretch with no idling on either side
		run_phase(7'd4, 7'd8, 24, 50, 1'b1);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** work_stealing_stack_pool: PASSED **");
		else
			$display("** work_stealing_stack_pool: FAILED **");
		$finish;
	end

endmodule
